>>> rtl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
`default_nettype none

package mts_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] mn;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    push;
        logic    pop;
        logic    load;
        logic    set_status;
        t_status status;
        logic    respond;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_pop;
        logic full;
        logic empty;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/mts_ctrl.sv
// Request sequencer for the min-tracking stack.
`default_nettype none

module mts_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire mts_pkg::t_dp_sts i_sts,
    output mts_pkg::t_dp_cmd      o_cmd,
    output logic                  o_busy
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LOAD = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = mts_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_RESP;
                if (i_sts.req_pop) begin
                    if (i_sts.empty) begin
                        o_cmd.status = mts_pkg::ST_EMPTY;
                    end else begin
                        // drop count and fetch the entry that becomes the new top
                        o_cmd.pop = 1'b1;
                        n_state   = S_LOAD;
                    end
                end else begin
                    if (i_sts.full) begin
                        o_cmd.status = mts_pkg::ST_FULL;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/mts_datapath.sv
// Entry memory, cached top entry, count and result registers.
`default_nettype none

module mts_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_req_type,
    input  wire logic signed [mts_pkg::DATA_W-1:0]   i_push_value,
    input  wire mts_pkg::t_dp_cmd                    i_cmd,
    output mts_pkg::t_dp_sts                         o_sts,
    output logic                                     o_valid,
    output logic signed [mts_pkg::DATA_W-1:0]        o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0]        o_min_value,
    output logic        [mts_pkg::CNT_W-1:0]         o_depth,
    output logic                                     o_is_empty,
    output logic        [1:0]                        o_status
);

    mts_pkg::t_entry mem [mts_pkg::DEPTH];

    logic                              r_req_type;
    logic signed [mts_pkg::DATA_W-1:0] r_push_value;
    logic        [mts_pkg::CNT_W-1:0]  r_count;
    logic signed [mts_pkg::DATA_W-1:0] r_top_val;
    logic signed [mts_pkg::DATA_W-1:0] r_top_min;
    mts_pkg::t_entry                   r_rd_data;
    mts_pkg::t_status                  r_status;
    logic                              r_valid;
    logic signed [mts_pkg::DATA_W-1:0] r_out_top;
    logic signed [mts_pkg::DATA_W-1:0] r_out_min;
    logic        [mts_pkg::CNT_W-1:0]  r_out_depth;
    logic                              r_out_empty;
    mts_pkg::t_status                  r_out_status;

    logic signed [mts_pkg::DATA_W-1:0] n_new_min;
    logic        [mts_pkg::CNT_W-1:0]  n_rd_cnt;
    logic        [mts_pkg::ADDR_W-1:0] wr_addr;
    logic        [mts_pkg::ADDR_W-1:0] rd_addr;
    logic                              cnt_zero;

    assign cnt_zero = (r_count == '0);
    // ties go to the pushed value; the minimum is the same either way
    assign n_new_min = (cnt_zero || (r_push_value <= r_top_min)) ? r_push_value : r_top_min;
    assign wr_addr   = r_count[mts_pkg::ADDR_W-1:0];
    // entry below the current top; wraps harmlessly when one entry is held
    assign n_rd_cnt  = r_count - mts_pkg::CNT_W'(2);
    assign rd_addr   = n_rd_cnt[mts_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[wr_addr] <= '{val: r_push_value, mn: n_new_min};
        end
        if (i_cmd.pop) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req_type   <= i_req_type;
            r_push_value <= i_push_value;
        end
        if (i_cmd.push) begin
            r_top_val <= r_push_value;
            r_top_min <= n_new_min;
        end else if (i_cmd.load) begin
            r_top_val <= r_rd_data.val;
            r_top_min <= r_rd_data.mn;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.respond) begin
            r_out_top    <= cnt_zero ? '0 : r_top_val;
            r_out_min    <= cnt_zero ? '0 : r_top_min;
            r_out_depth  <= r_count;
            r_out_empty  <= cnt_zero;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.respond;
            if (i_cmd.push) begin
                r_count <= r_count + mts_pkg::CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - mts_pkg::CNT_W'(1);
            end
        end
    end

    assign o_sts.req_pop = (r_req_type == mts_pkg::REQ_POP);
    assign o_sts.full    = (r_count == mts_pkg::CNT_W'(mts_pkg::DEPTH));
    assign o_sts.empty   = cnt_zero;

    assign o_valid     = r_valid;
    assign o_top_value = r_out_top;
    assign o_min_value = r_out_min;
    assign o_depth     = r_out_depth;
    assign o_is_empty  = r_out_empty;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

>>> rtl/min_tracking_stack_unit.sv
// Top level of the min-tracking stack: sequencer plus datapath.
//
// A 64-entry stack of signed 32-bit words that keeps, with every entry, the
// minimum of that entry and all below it. Raise start with a request while
// busy is low; busy then stays high until the result has been launched. A
// push runs EXEC then RESP before the o_valid strobe, a pop EXEC, LOAD,
// RESP (LOAD copies the registered read of the entry-memory port into the
// cached top). busy falls as o_valid is registered, so a new request is
// taken no earlier than the edge that ends the o_valid strobe. The result
// is on the outputs for the single cycle that o_valid is high and cannot
// be stalled, so capture it then. A push onto a full stack reports status
// 1, a pop on an empty stack status 2; neither changes the stack. An
// empty stack reports zero top and minimum values.
`default_nettype none

module min_tracking_stack_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_req_type,
    input  wire logic signed [mts_pkg::DATA_W-1:0]   i_push_value,
    output logic                                     o_valid,
    output logic signed [mts_pkg::DATA_W-1:0]        o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0]        o_min_value,
    output logic        [mts_pkg::CNT_W-1:0]         o_depth,
    output logic                                     o_is_empty,
    output logic        [1:0]                        o_status
);

    mts_pkg::t_dp_cmd dp_cmd;
    mts_pkg::t_dp_sts dp_sts;

    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    mts_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .o_valid      (o_valid),
        .o_top_value  (o_top_value),
        .o_min_value  (o_min_value),
        .o_depth      (o_depth),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

    // accepted request keeps the block busy until its result goes out
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_depth == '0)))
        else $error("empty flag disagrees with depth");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mts_pkg::ST_FULL))
            |-> (o_depth == mts_pkg::CNT_W'(mts_pkg::DEPTH)))
        else $error("overflow reported below full depth");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == mts_pkg::ST_EMPTY)) |-> o_is_empty)
        else $error("underflow reported on non-empty stack");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the min-tracking stack unit.
`timescale 1ns / 100ps

module tb;

    localparam logic signed [mts_pkg::DATA_W-1:0] WORD_MAX =
        {1'b0, {(mts_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [mts_pkg::DATA_W-1:0] WORD_MIN =
        {1'b1, {(mts_pkg::DATA_W-1){1'b0}}};
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic signed [mts_pkg::DATA_W-1:0] top_value;
        logic signed [mts_pkg::DATA_W-1:0] min_value;
        logic        [mts_pkg::CNT_W-1:0]  depth;
        logic                              is_empty;
        mts_pkg::t_status                  status;
    } t_stack_view;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_req_type;
    logic signed [mts_pkg::DATA_W-1:0] i_push_value;
    logic                              o_valid;
    logic signed [mts_pkg::DATA_W-1:0] o_top_value;
    logic signed [mts_pkg::DATA_W-1:0] o_min_value;
    logic        [mts_pkg::CNT_W-1:0]  o_depth;
    logic                              o_is_empty;
    logic        [1:0]                 o_status;

    // shadow copy of the stack
    logic signed [mts_pkg::DATA_W-1:0] shadow_vals [mts_pkg::DEPTH];
    logic signed [mts_pkg::DATA_W-1:0] shadow_mins [mts_pkg::DEPTH];
    int                                shadow_held;

    t_stack_view pending_views [$];
    t_stack_view seen_view;
    t_stack_view want_view;
    int          fail_count;
    bit          idle_on;

    min_tracking_stack_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_top_value  (o_top_value),
        .o_min_value  (o_min_value),
        .o_depth      (o_depth),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Apply one request to the shadow stack and return the view it leaves.
    function automatic t_stack_view next_stack_view(
        logic req, logic signed [mts_pkg::DATA_W-1:0] value);
        t_stack_view                       view;
        logic signed [mts_pkg::DATA_W-1:0] new_min;
        view.status = mts_pkg::ST_OK;
        if (req == mts_pkg::REQ_PUSH) begin
            if (shadow_held == mts_pkg::DEPTH) begin
                view.status = mts_pkg::ST_FULL;
            end else begin
                new_min = value;
                // ties keep the pushed value; same minimum either way
                if (shadow_held > 0 && !(value <= shadow_mins[shadow_held-1]))
                    new_min = shadow_mins[shadow_held-1];
                shadow_vals[shadow_held] = value;
                shadow_mins[shadow_held] = new_min;
                shadow_held++;
            end
        end else begin
            if (shadow_held == 0)
                view.status = mts_pkg::ST_EMPTY;
            else
                shadow_held--;
        end
        view.top_value = (shadow_held > 0) ? shadow_vals[shadow_held-1] : '0;
        view.min_value = (shadow_held > 0) ? shadow_mins[shadow_held-1] : '0;
        view.depth     = shadow_held[mts_pkg::CNT_W-1:0];
        view.is_empty  = (shadow_held == 0);
        return view;
    endfunction

    // Mix of extremes, a narrow band (to force ties) and full-range words.
    function automatic logic signed [mts_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3: return mts_pkg::DATA_W'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Issue one request, wait for acceptance, record its expected view.
    task automatic send_request(logic req, logic signed [mts_pkg::DATA_W-1:0] value);
        start        <= 1'b1;
        i_req_type   <= req;
        i_push_value <= value;
        do @(posedge i_clk); while (busy);
        pending_views.push_back(next_stack_view(req, value));
        if (idle_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_view.top_value = o_top_value;
            seen_view.min_value = o_min_value;
            seen_view.depth     = o_depth;
            seen_view.is_empty  = o_is_empty;
            seen_view.status    = mts_pkg::t_status'(o_status);
            if (pending_views.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: top %h min %h depth %0d",
                             o_top_value, o_min_value, o_depth);
            end else begin
                want_view = pending_views.pop_front();
                if (seen_view.top_value !== want_view.top_value ||
                    seen_view.min_value !== want_view.min_value ||
                    seen_view.depth     !== want_view.depth     ||
                    seen_view.is_empty  !== want_view.is_empty  ||
                    seen_view.status    !== want_view.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch (exp/act): top %h/%h min %h/%h",
                                 want_view.top_value, seen_view.top_value,
                                 want_view.min_value, seen_view.min_value,
                                 " depth %0d/%0d empty %0b/%0b status %0d/%0d",
                                 want_view.depth, seen_view.depth,
                                 want_view.is_empty, seen_view.is_empty,
                                 want_view.status, seen_view.status);
                end
            end
        end
    end

    // Extremes, ties, and underflow on an empty stack.
    task automatic test_directed();
        idle_on = 1'b1;
        send_request(mts_pkg::REQ_POP, WORD_MAX);
        send_request(mts_pkg::REQ_PUSH, WORD_MAX);
        send_request(mts_pkg::REQ_PUSH, WORD_MIN);
        send_request(mts_pkg::REQ_PUSH, WORD_MIN);
        send_request(mts_pkg::REQ_PUSH, '0);
        send_request(mts_pkg::REQ_PUSH, -1);
        send_request(mts_pkg::REQ_PUSH, 1);
        repeat (6) send_request(mts_pkg::REQ_POP, '0);
        send_request(mts_pkg::REQ_POP, -1);
        send_request(mts_pkg::REQ_PUSH, -1);
        send_request(mts_pkg::REQ_PUSH, -2);
        send_request(mts_pkg::REQ_PUSH, -2);
        send_request(mts_pkg::REQ_PUSH, 5);
        send_request(mts_pkg::REQ_PUSH, 5);
        repeat (5) send_request(mts_pkg::REQ_POP, WORD_MIN);
        send_request(mts_pkg::REQ_POP, '0);
    endtask

    // Fill past full (overflow), then drain past empty (underflow).
    task automatic test_fill_drain();
        idle_on = 1'($urandom_range(0, 1));
        while (shadow_held < mts_pkg::DEPTH) send_request(mts_pkg::REQ_PUSH, pick_word());
        repeat ($urandom_range(1, 3)) send_request(mts_pkg::REQ_PUSH, pick_word());
        send_request(mts_pkg::REQ_POP, $urandom);
        send_request(mts_pkg::REQ_PUSH, pick_word());
        send_request(mts_pkg::REQ_PUSH, pick_word());
        while (shadow_held > 0) send_request(mts_pkg::REQ_POP, $urandom);
        repeat ($urandom_range(1, 2)) send_request(mts_pkg::REQ_POP, $urandom);
    endtask

    // Random push/pop walk; push bias changes per stretch to sweep depth.
    task automatic test_random_walk(int items, bit allow_idle);
        int push_pct;
        int n;
        push_pct = 50;
        for (n = 0; n < items; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: push_pct = 30;
                    1: push_pct = 50;
                    2: push_pct = 70;
                    default: push_pct = 90;
                endcase
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(1, 100) <= push_pct)
                send_request(mts_pkg::REQ_PUSH, pick_word());
            else
                send_request(mts_pkg::REQ_POP, $urandom);
        end
    endtask

    initial begin
        fail_count   = 0;
        shadow_held  = 0;
        idle_on      = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_req_type   <= mts_pkg::REQ_PUSH;
        i_push_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_drain();
        test_random_walk(300, 1'b1);
        test_fill_drain();
        test_random_walk(150, 1'b0);
        start <= 1'b0;

        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_views.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
